/* design/cfwr_pkg.sv */
package cfwr_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REVERSE = 2'd2;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] pop_value;
        logic [OCC_W-1:0]   occupancy;
    } cfwr_res_t;

endpackage

/* design/cfwr_req_if.sv */
interface cfwr_req_if
    import cfwr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink (input valid, input kind, input push_value, output ready);
endinterface

/* design/cfwr_rsp_if.sv */
interface cfwr_rsp_if
    import cfwr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [VALUE_W-1:0] pop_value;
    logic [OCC_W-1:0]   occupancy;

    modport source (output valid, output ok, output pop_value, output occupancy, input ready);
    modport sink (input valid, input ok, input pop_value, input occupancy, output ready);
endinterface

/* design/circular_fifo_with_reverse_unit.sv */
// A push, a refused pop and the unused code go straight to the done state; a successful pop
// reads the head slot first; a reverse swaps occupancy / 2 slot pairs over one read port.
// Only one transaction is in work at a time: req.ready is low while a request is in work
// and until its result is taken into the response register.
// Reset: asynchronous, active low; clears head, tail and count. Slot RAM is not cleared.
module circular_fifo_with_reverse_unit
    import cfwr_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cfwr_req_if.sink   req,
    cfwr_rsp_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  idle;
    logic                  res_valid;
    cfwr_res_t             res;
    logic                  res_take;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic                  out_valid_reg, out_valid_next;
    cfwr_res_t             out_reg, out_next;

    cfwr_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (req.valid && idle),
        .kind       (req.kind),
        .push_value (req.push_value),
        .idle       (idle),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    cfwr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign req.ready     = idle;
    assign rsp.valid     = out_valid_reg;
    assign rsp.ok        = out_reg.ok;
    assign rsp.pop_value = out_reg.pop_value;
    assign rsp.occupancy = out_reg.occupancy;

endmodule

/* design/cfwr_ram.sv */
module cfwr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/cfwr_idx_unit.sv */
module cfwr_idx_unit #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic [AW-1:0] idx,
    input  logic          dec,
    output logic [AW-1:0] result
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    always_comb
    begin
        if (dec)
        begin
            result = (idx == '0) ? LAST : idx - AW'(1);
        end
        else
        begin
            result = (idx == LAST) ? '0 : idx + AW'(1);
        end
    end

endmodule

/* design/cfwr_ctrl.sv */
module cfwr_ctrl
    import cfwr_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [KIND_W-1:0]     kind,
    input  logic [VALUE_W-1:0]    push_value,
    output logic                  idle,
    output logic                  res_valid,
    output cfwr_res_t             res,
    input  logic                  res_take,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [DATA_WIDTH-1:0] mem_wdata,
    output logic [AW-1:0]         mem_raddr,
    input  logic [DATA_WIDTH-1:0] mem_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_REV_INIT,
        ST_RD_LO,
        ST_RD_HI,
        ST_WR_LO,
        ST_WR_HI,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         lo_reg, lo_next;
    logic [AW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         swaps_reg, swaps_next;
    logic [DATA_WIDTH-1:0] tmp_reg, tmp_next;
    logic                  ok_reg, ok_next;
    logic [VALUE_W-1:0]    pop_reg, pop_next;

    logic [AW-1:0] unit_idx;
    logic          unit_dec;
    logic [AW-1:0] unit_result;

    cfwr_idx_unit #(.DEPTH(DEPTH)) u_idx (
        .idx    (unit_idx),
        .dec    (unit_dec),
        .result (unit_result)
    );

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        swaps_next = swaps_reg;
        tmp_next   = tmp_reg;
        ok_next    = ok_reg;
        pop_next   = pop_reg;
        unit_idx   = head_reg;
        unit_dec   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = tail_reg;
        mem_wdata  = DATA_WIDTH'(push_value);
        mem_raddr  = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ok_next  = 1'b0;
                    pop_next = '0;
                    case (kind)
                        KIND_PUSH:
                        begin
                            unit_idx   = tail_reg;
                            state_next = ST_DONE;
                            if (count_reg < CW'(DEPTH))
                            begin
                                mem_we     = 1'b1;
                                tail_next  = unit_result;
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            state_next = (count_reg != '0) ? ST_POP_RD : ST_DONE;
                        end
                        KIND_REVERSE:
                        begin
                            ok_next    = 1'b1;
                            swaps_next = count_reg >> 1;
                            state_next = ST_REV_INIT;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_POP_RD:
            begin
                pop_next   = VALUE_W'(mem_rdata);
                ok_next    = 1'b1;
                head_next  = unit_result;
                count_next = count_reg - CW'(1);
                state_next = ST_DONE;
            end
            ST_REV_INIT:
            begin
                unit_idx   = tail_reg;
                unit_dec   = 1'b1;
                hi_next    = unit_result;
                lo_next    = head_reg;
                state_next = (swaps_reg == '0) ? ST_DONE : ST_RD_LO;
            end
            ST_RD_LO:
            begin
                mem_raddr  = lo_reg;
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                mem_raddr  = hi_reg;
                tmp_next   = mem_rdata;
                state_next = ST_WR_LO;
            end
            ST_WR_LO:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg;
                mem_wdata  = mem_rdata;
                unit_idx   = lo_reg;
                lo_next    = unit_result;
                state_next = ST_WR_HI;
            end
            ST_WR_HI:
            begin
                mem_we     = 1'b1;
                mem_waddr  = hi_reg;
                mem_wdata  = tmp_reg;
                unit_idx   = hi_reg;
                unit_dec   = 1'b1;
                hi_next    = unit_result;
                swaps_next = swaps_reg - CW'(1);
                state_next = (swaps_reg == CW'(1)) ? ST_DONE : ST_RD_LO;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            swaps_reg <= '0;
            tmp_reg   <= '0;
            ok_reg    <= 1'b0;
            pop_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            swaps_reg <= swaps_next;
            tmp_reg   <= tmp_next;
            ok_reg    <= ok_next;
            pop_reg   <= pop_next;
        end
    end

    assign idle          = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);
    assign res.ok        = ok_reg;
    assign res.pop_value = pop_reg;
    assign res.occupancy = OCC_W'(count_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && (count_reg == '0 || count_reg == CW'(DEPTH)))
            |-> head_reg == tail_reg)
        else $error("head and tail disagree at empty or full");

    a_swap_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR_LO |-> lo_reg != hi_reg)
        else $error("swap of a slot with itself");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !res_take)
            |=> state_reg == ST_DONE && $stable(ok_reg) && $stable(pop_reg))
        else $error("pending result changed before transfer");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top;
    import cfwr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDX_W       = $clog2(DEPTH_DEF);
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 200000;

    class fifo_scoreboard;
        logic [VALUE_W-1:0] slots [DEPTH_DEF];
        logic [IDX_W-1:0]   head;
        logic [IDX_W-1:0]   tail;
        logic [OCC_W-1:0]   count;
        cfwr_res_t          expected_q [$];
        int                 errors;

        function new();
            head   = '0;
            tail   = '0;
            count  = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(input logic [KIND_W-1:0] kind,
                                   input logic [VALUE_W-1:0] value);
            cfwr_res_t          res;
            logic [IDX_W-1:0]   lo;
            logic [IDX_W-1:0]   hi;
            logic [VALUE_W-1:0] tmp;
            res = '0;
            case (kind)
                KIND_PUSH:
                begin
                    if (count < DEPTH_DEF)
                    begin
                        slots[tail] = value;
                        tail        = tail + 1'b1;
                        count       = count + 1'b1;
                        res.ok      = 1'b1;
                    end
                end
                KIND_POP:
                begin
                    if (count > 0)
                    begin
                        res.pop_value = slots[head];
                        head          = head + 1'b1;
                        count         = count - 1'b1;
                        res.ok        = 1'b1;
                    end
                end
                KIND_REVERSE:
                begin
                    lo = head;
                    hi = tail - 1'b1;
                    for (int k = 0; k < count / 2; k++)
                    begin
                        tmp       = slots[lo];
                        slots[lo] = slots[hi];
                        slots[hi] = tmp;
                        lo        = lo + 1'b1;
                        hi        = hi - 1'b1;
                    end
                    res.ok = 1'b1;
                end
                default:
                begin
                end
            endcase
            res.occupancy = count;
            expected_q.push_back(res);
        endfunction

        function void check_response(input cfwr_res_t got);
            cfwr_res_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("unexpected response: ok %0d pop_value %h occupancy %0d",
                       got.ok, got.pop_value, got.occupancy);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.ok !== exp_res.ok)
            begin
                $error("ok: expected %0d, actual %0d", exp_res.ok, got.ok);
                errors++;
            end
            if (got.pop_value !== exp_res.pop_value)
            begin
                $error("pop_value: expected %h, actual %h", exp_res.pop_value, got.pop_value);
                errors++;
            end
            if (got.occupancy !== exp_res.occupancy)
            begin
                $error("occupancy: expected %0d, actual %0d", exp_res.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    int   cycle_count = 0;

    fifo_scoreboard sb = new();

    cfwr_req_if req_bus ();
    cfwr_rsp_if rsp_bus ();

    circular_fifo_with_reverse_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge clk)
    begin
        if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response('{rsp_bus.ok, rsp_bus.pop_value, rsp_bus.occupancy});
        rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 27);
    end

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
        while (!quiet && $urandom_range(0, 99) < 27)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.kind       <= kind;
        req_bus.push_value <= value;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        sb.note_request(kind, value);
    endtask

    task automatic wait_drain();
        req_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        else if (roll < 10)
            return '1;
        else
            return $urandom;
    endfunction

    task automatic run_directed();
        send_request(KIND_POP, 32'h1234_5678);
        send_request(KIND_REVERSE, '1);
        send_request(KIND_UNUSED, '1);
        send_request(KIND_PUSH, 32'hFFFF_FFFF);
        send_request(KIND_REVERSE, '0);
        send_request(KIND_POP, '0);
        send_request(KIND_PUSH, 32'h0000_0000);
        send_request(KIND_PUSH, 32'hAAAA_AAAA);
        send_request(KIND_PUSH, 32'h5555_5555);
        for (int i = 3; i < DEPTH_DEF; i++)
            send_request(KIND_PUSH, $urandom);
        send_request(KIND_PUSH, 32'hDEAD_BEEF);
        send_request(KIND_REVERSE, '0);
        send_request(KIND_UNUSED, '0);
    endtask

    task automatic run_random(input int n);
        int                 sent;
        int                 target;
        int                 roll;
        logic [KIND_W-1:0]  kind;
        sent   = 0;
        target = $urandom_range(0, DEPTH_DEF);
        while (sent < n)
        begin
            quiet = (sent >= 150 && sent < 230);
            if (sent == 100 || sent == 300)
                wait_drain();
            roll = $urandom_range(0, 99);
            if (roll < 3)
                kind = KIND_UNUSED;
            else if (roll < 15)
                kind = KIND_REVERSE;
            else if (sb.count < target)
                kind = (roll < 85) ? KIND_PUSH : KIND_POP;
            else if (sb.count > target)
                kind = (roll < 85) ? KIND_POP : KIND_PUSH;
            else
            begin
                kind = roll[0] ? KIND_PUSH : KIND_POP;
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    target = 0;
                else if (roll < 60)
                    target = DEPTH_DEF;
                else
                    target = $urandom_range(0, DEPTH_DEF);
            end
            send_request(kind, pick_value());
            if (kind != KIND_UNUSED)
                sent++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        quiet              = 1'b0;
        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.kind       <= KIND_PUSH;
        req_bus.push_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drain();
        run_random(RANDOM_ITEMS);
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
